// ===== hdl/pglt_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed group list table: shared definitions
// Sizes, field widths, mode and status codes, and the command and status
// bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package pglt_pkg;

    localparam int MAX_GROUPS   = 128;
    localparam int BUFFER_DEPTH = 512;
    localparam int MEMBER_IDS   = 1024;

    // request and result fields
    localparam int MODE_W   = 3;
    localparam int GROUP_W  = 7;
    localparam int MEMBER_W = 10;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 10;

    // storage widths
    localparam int GA_W   = $clog2(MAX_GROUPS);
    localparam int TOT_W  = $clog2(MAX_GROUPS + 1);
    localparam int HOME_W = TOT_W;
    localparam int BUF_AW = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int MID_AW = $clog2(MEMBER_IDS);
    localparam int MID_CW = $clog2(MEMBER_IDS + 1);
    localparam int SIZE_W = 10;
    localparam int SUM_W  = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;
    localparam int IDX_W  = ((FILL_W > MID_CW) ? FILL_W : MID_CW) + 1;

    localparam logic [SIZE_W-1:0] SIZE_CAP  = SIZE_W'(1023);
    localparam logic [HOME_W-1:0] HOME_NONE = HOME_W'(MAX_GROUPS);

    localparam logic [MODE_W-1:0] MODE_TEST   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DROP_M = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DROP_G = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [4:0] {
        OP_CLEAR,
        OP_IDLE,
        OP_CHECK,
        OP_CREATE,
        OP_SPAN,
        OP_APPEND,
        OP_R7,
        OP_TEST_RD,
        OP_TEST_CK,
        OP_DM_RD,
        OP_DM_CK,
        OP_CUT_RD,
        OP_CUT_WR,
        OP_LOW_RD,
        OP_LOW_WR,
        OP_HOME_RD,
        OP_HOME_WR,
        OP_MVA_RD,
        OP_MVA_WR,
        OP_MVB_RD,
        OP_MVB_WR,
        OP_MVC_RD,
        OP_MVC_WR,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              grp_ok;
        logic              done;
        logic              hit;
        logic              skip;
        logic              bad7;
    } sts_t;

endpackage

// ===== hdl/pglt_dpath.sv =====
// ----------------------------------------------------------------------------
// Packed group list table: datapath
// Group records, member buffer, scratch buffer and back-pointer store, with
// the counters and arithmetic for each sequencer step.
// ----------------------------------------------------------------------------
module pglt_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pglt_pkg::cmd_t                 cmd,
    input  logic [pglt_pkg::MODE_W-1:0]    mode,
    input  logic [pglt_pkg::GROUP_W-1:0]   group,
    input  logic [pglt_pkg::MEMBER_W-1:0]  member,
    input  logic [pglt_pkg::POS_W-1:0]     position,
    output pglt_pkg::sts_t                 sts,
    output logic [pglt_pkg::STATUS_W-1:0]  status,
    output logic                           found,
    output logic [pglt_pkg::VALUE_W-1:0]   value
);

    localparam int FW = pglt_pkg::FILL_W;
    localparam int IW = pglt_pkg::IDX_W;
    localparam int SW = pglt_pkg::SUM_W;

    // memories
    logic [FW-1:0]                   start_mem [pglt_pkg::MAX_GROUPS];
    logic [pglt_pkg::SIZE_W-1:0]     size_mem  [pglt_pkg::MAX_GROUPS];
    logic [pglt_pkg::MEMBER_W-1:0]   store_mem [pglt_pkg::BUFFER_DEPTH];
    logic [pglt_pkg::MEMBER_W-1:0]   scr_mem   [pglt_pkg::BUFFER_DEPTH];
    logic [pglt_pkg::HOME_W-1:0]     home_mem  [pglt_pkg::MEMBER_IDS];

    logic [FW-1:0]                   start_q;
    logic [pglt_pkg::SIZE_W-1:0]     size_q;
    logic [pglt_pkg::MEMBER_W-1:0]   store_q;
    logic [pglt_pkg::MEMBER_W-1:0]   scr_q;
    logic [pglt_pkg::HOME_W-1:0]     home_q;

    logic [pglt_pkg::GA_W-1:0]       g_ra, g_wa;
    logic                            start_we, size_we;
    logic [FW-1:0]                   start_wd;
    logic [pglt_pkg::SIZE_W-1:0]     size_wd;
    logic [pglt_pkg::BUF_AW-1:0]     store_ra, store_wa, scr_ra, scr_wa;
    logic                            store_we, scr_we;
    logic [pglt_pkg::MEMBER_W-1:0]   store_wd, scr_wd;
    logic [pglt_pkg::MID_AW-1:0]     home_ra, home_wa;
    logic                            home_we;
    logic [pglt_pkg::HOME_W-1:0]     home_wd;

    // request and working registers
    logic [pglt_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [pglt_pkg::GROUP_W-1:0]    grp_reg, grp_next;
    logic [pglt_pkg::MEMBER_W-1:0]   mbr_reg, mbr_next;
    logic [pglt_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [pglt_pkg::TOT_W-1:0]      total_reg, total_next;
    logic [FW-1:0]                   fill_reg, fill_next;
    logic [FW-1:0]                   s_reg, s_next, e_reg, e_next, cnt_reg, cnt_next;
    logic [pglt_pkg::SIZE_W-1:0]     gsize_reg, gsize_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [pglt_pkg::STATUS_W-1:0]   res_st_reg, res_st_next;
    logic                            res_fd_reg, res_fd_next;
    logic [pglt_pkg::VALUE_W-1:0]    res_val_reg, res_val_next;
    logic [pglt_pkg::STATUS_W-1:0]   out_st_reg;
    logic                            out_fd_reg;
    logic [pglt_pkg::VALUE_W-1:0]    out_val_reg;

    // span of the addressed group, cut at the fill level
    logic [FW-1:0]                   span_a, span_e;
    logic [SW-1:0]                   span_b, addr7;
    logic                            bad7;
    logic                            grp_ok, id_bad;
    logic [IW:0]                     idx_sum;
    logic [FW-1:0]                   lowered;
    logic [pglt_pkg::GA_W-1:0]       li;
    logic [pglt_pkg::GA_W-1:0]       grp_ga;

    assign grp_ga = grp_reg[pglt_pkg::GA_W-1:0];
    assign grp_ok = pglt_pkg::TOT_W'(grp_reg) < total_reg;
    assign id_bad = (pglt_pkg::MEMBER_W+1)'(mbr_reg) >=
                    (pglt_pkg::MEMBER_W+1)'(pglt_pkg::MEMBER_IDS);

    always_comb
    begin
        span_a = (start_q > fill_reg) ? fill_reg : start_q;
        span_b = SW'(span_a) + SW'(size_q);
        span_e = (span_b > SW'(fill_reg)) ? fill_reg : span_a + FW'(size_q);
        addr7  = SW'(start_q) + SW'(pos_reg);
        bad7   = (SW'(pos_reg) >= SW'(size_q)) || (addr7 >= SW'(fill_reg)) ||
                 (addr7 >= SW'(pglt_pkg::BUFFER_DEPTH));
        idx_sum = (IW+1)'(idx_reg) + (IW+1)'(cnt_reg);
        li      = idx_reg[pglt_pkg::GA_W-1:0];
        if (start_q > s_reg)
            lowered = (start_q > cnt_reg) ? start_q - cnt_reg : '0;
        else
            lowered = start_q;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        grp_next     = grp_reg;
        mbr_next     = mbr_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        fill_next    = fill_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        cnt_next     = cnt_reg;
        gsize_next   = gsize_reg;
        idx_next     = idx_reg;
        res_st_next  = res_st_reg;
        res_fd_next  = res_fd_reg;
        res_val_next = res_val_reg;

        g_ra     = grp_ga;
        g_wa     = grp_ga;
        start_we = 1'b0;
        start_wd = fill_reg;
        size_we  = 1'b0;
        size_wd  = gsize_reg;
        store_ra = idx_reg[pglt_pkg::BUF_AW-1:0];
        store_we = 1'b0;
        store_wa = idx_reg[pglt_pkg::BUF_AW-1:0];
        store_wd = store_q;
        scr_ra   = idx_reg[pglt_pkg::BUF_AW-1:0];
        scr_we   = 1'b0;
        scr_wa   = idx_reg[pglt_pkg::BUF_AW-1:0];
        scr_wd   = store_q;
        home_ra  = idx_reg[pglt_pkg::MID_AW-1:0];
        home_we  = 1'b0;
        home_wa  = idx_reg[pglt_pkg::MID_AW-1:0];
        home_wd  = pglt_pkg::HOME_NONE;

        sts.mode   = mode_reg;
        sts.grp_ok = grp_ok;
        sts.done   = 1'b0;
        sts.hit    = (store_q == mbr_reg);
        sts.skip   = (span_e == fill_reg);
        sts.bad7   = bad7;

        unique case (cmd.op)
            pglt_pkg::OP_CLEAR:
            begin
                home_we  = 1'b1;
                sts.done = (idx_reg == IW'(pglt_pkg::MEMBER_IDS - 1));
                idx_next = sts.done ? '0 : idx_reg + 1'b1;
            end
            pglt_pkg::OP_IDLE:
            begin
                if (cmd.take)
                begin
                    mode_next    = mode;
                    grp_next     = group;
                    mbr_next     = member;
                    pos_next     = position;
                    res_st_next  = pglt_pkg::ST_OK;
                    res_fd_next  = 1'b0;
                    res_val_next = '0;
                end
            end
            pglt_pkg::OP_CHECK:
            begin
                if (mode_reg != pglt_pkg::MODE_CREATE && !grp_ok)
                    res_st_next = pglt_pkg::ST_BAD;
            end
            pglt_pkg::OP_CREATE:
            begin
                if (total_reg >= pglt_pkg::TOT_W'(pglt_pkg::MAX_GROUPS) ||
                    fill_reg >= FW'(pglt_pkg::BUFFER_DEPTH))
                    res_st_next = pglt_pkg::ST_FULL;
                else if (id_bad)
                    res_st_next = pglt_pkg::ST_BAD;
                else
                begin
                    g_wa         = total_reg[pglt_pkg::GA_W-1:0];
                    start_we     = 1'b1;
                    start_wd     = fill_reg;
                    size_we      = 1'b1;
                    size_wd      = pglt_pkg::SIZE_W'(1);
                    home_we      = 1'b1;
                    home_wa      = mbr_reg[pglt_pkg::MID_AW-1:0];
                    home_wd      = total_reg;
                    store_we     = 1'b1;
                    store_wa     = fill_reg[pglt_pkg::BUF_AW-1:0];
                    store_wd     = mbr_reg;
                    res_val_next = pglt_pkg::VALUE_W'(total_reg);
                    total_next   = total_reg + 1'b1;
                    fill_next    = fill_reg + 1'b1;
                end
            end
            pglt_pkg::OP_SPAN:
            begin
                s_next     = span_a;
                e_next     = span_e;
                cnt_next   = span_e - span_a;
                // the move sweeps count from zero, the others from the span start
                idx_next   = (mode_reg == pglt_pkg::MODE_MOVE) ? '0 : IW'(span_a);
                gsize_next = size_q;
                store_ra   = addr7[pglt_pkg::BUF_AW-1:0];
                if (mode_reg == pglt_pkg::MODE_COUNT)
                    res_val_next = pglt_pkg::VALUE_W'(size_q);
                if (mode_reg == pglt_pkg::MODE_READ && bad7)
                    res_st_next = pglt_pkg::ST_BAD;
            end
            pglt_pkg::OP_APPEND:
            begin
                if (fill_reg >= FW'(pglt_pkg::BUFFER_DEPTH))
                    res_st_next = pglt_pkg::ST_FULL;
                else if (id_bad)
                    res_st_next = pglt_pkg::ST_BAD;
                else
                begin
                    store_we  = 1'b1;
                    store_wa  = fill_reg[pglt_pkg::BUF_AW-1:0];
                    store_wd  = mbr_reg;
                    size_we   = 1'b1;
                    size_wd   = (gsize_reg < pglt_pkg::SIZE_CAP) ? gsize_reg + 1'b1
                                                                 : gsize_reg;
                    home_we   = 1'b1;
                    home_wa   = mbr_reg[pglt_pkg::MID_AW-1:0];
                    home_wd   = pglt_pkg::HOME_W'(grp_reg);
                    fill_next = fill_reg + 1'b1;
                end
            end
            pglt_pkg::OP_R7:
            begin
                res_val_next = store_q;
            end
            pglt_pkg::OP_TEST_RD:
            begin
                sts.done = (idx_reg >= IW'(e_reg));
            end
            pglt_pkg::OP_TEST_CK:
            begin
                if (store_q == mbr_reg)
                    res_fd_next = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_DM_RD:
            begin
                sts.done = (idx_reg >= IW'(e_reg));
                if (sts.done)
                    res_st_next = pglt_pkg::ST_BAD;
            end
            pglt_pkg::OP_DM_CK:
            begin
                if (store_q == mbr_reg)
                begin
                    cnt_next = FW'(1);
                    size_we  = 1'b1;
                    size_wd  = gsize_reg - 1'b1;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_CUT_RD:
            begin
                store_ra = idx_sum[pglt_pkg::BUF_AW-1:0];
                sts.done = (idx_sum >= (IW+1)'(fill_reg));
                if (sts.done)
                begin
                    fill_next = fill_reg - cnt_reg;
                    idx_next  = '0;
                end
            end
            pglt_pkg::OP_CUT_WR:
            begin
                store_we = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_LOW_RD:
            begin
                g_ra     = li;
                sts.done = (idx_reg >= IW'(total_reg));
                if (sts.done)
                begin
                    idx_next = '0;
                    if (mode_reg == pglt_pkg::MODE_DROP_G)
                        total_next = total_reg - 1'b1;
                end
            end
            pglt_pkg::OP_LOW_WR:
            begin
                size_wd = size_q;
                if (mode_reg == pglt_pkg::MODE_DROP_G)
                begin
                    // lower later starts and close up the record list in one pass
                    start_we = (li != grp_ga);
                    size_we  = (li != grp_ga);
                    g_wa     = (li > grp_ga) ? li - 1'b1 : li;
                    start_wd = lowered;
                end
                else
                begin
                    start_we = 1'b1;
                    g_wa     = li;
                    start_wd = (li == grp_ga) ? fill_reg - cnt_reg : lowered;
                end
                idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_HOME_RD:
            begin
                sts.done = (idx_reg == IW'(pglt_pkg::MEMBER_IDS));
                if (sts.done)
                    idx_next = '0;
            end
            pglt_pkg::OP_HOME_WR:
            begin
                if (home_q != pglt_pkg::HOME_NONE)
                begin
                    if (home_q > pglt_pkg::HOME_W'(grp_reg))
                    begin
                        home_we = 1'b1;
                        home_wd = home_q - 1'b1;
                    end
                    else if (home_q == pglt_pkg::HOME_W'(grp_reg))
                        home_we = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_MVA_RD:
            begin
                store_ra = pglt_pkg::BUF_AW'(IW'(s_reg) + idx_reg);
                sts.done = (idx_reg >= IW'(cnt_reg));
                if (sts.done)
                    idx_next = '0;
            end
            pglt_pkg::OP_MVA_WR:
            begin
                scr_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_MVB_RD:
            begin
                store_ra = pglt_pkg::BUF_AW'(IW'(e_reg) + idx_reg);
                sts.done = (idx_reg >= IW'(fill_reg - e_reg));
                if (sts.done)
                    idx_next = '0;
            end
            pglt_pkg::OP_MVB_WR:
            begin
                store_we = 1'b1;
                store_wa = pglt_pkg::BUF_AW'(IW'(s_reg) + idx_reg);
                idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_MVC_RD:
            begin
                sts.done = (idx_reg >= IW'(cnt_reg));
                if (sts.done)
                    idx_next = '0;
            end
            pglt_pkg::OP_MVC_WR:
            begin
                store_we = 1'b1;
                store_wa = pglt_pkg::BUF_AW'(IW'(fill_reg - cnt_reg) + idx_reg);
                store_wd = scr_q;
                idx_next = idx_reg + 1'b1;
            end
            pglt_pkg::OP_FINISH:
            begin
                idx_next = '0;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[g_wa] <= start_wd;
        if (size_we)
            size_mem[g_wa] <= size_wd;
        start_q <= start_mem[g_ra];
        size_q  <= size_mem[g_ra];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_wa] <= store_wd;
        store_q <= store_mem[store_ra];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[scr_wa] <= scr_wd;
        scr_q <= scr_mem[scr_ra];
    end

    always_ff @(posedge clk)
    begin
        if (home_we)
            home_mem[home_wa] <= home_wd;
        home_q <= home_mem[home_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        grp_reg     <= grp_next;
        mbr_reg     <= mbr_next;
        pos_reg     <= pos_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        cnt_reg     <= cnt_next;
        gsize_reg   <= gsize_next;
        res_st_reg  <= res_st_next;
        res_fd_reg  <= res_fd_next;
        res_val_reg <= res_val_next;
        if (cmd.load)
        begin
            out_st_reg  <= res_st_reg;
            out_fd_reg  <= res_fd_reg;
            out_val_reg <= res_val_reg;
        end
    end

    assign status = out_st_reg;
    assign found  = out_fd_reg;
    assign value  = out_val_reg;

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(pglt_pkg::BUFFER_DEPTH))
        else $error("buffer fill beyond depth");

    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= pglt_pkg::TOT_W'(pglt_pkg::MAX_GROUPS))
        else $error("group count beyond table size");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pglt_pkg::OP_IDLE |-> idx_reg == '0)
        else $error("sweep index not cleared between requests");

    a_fill_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pglt_pkg::OP_TEST_CK |=> $stable(fill_reg))
        else $error("membership test changed the fill level");

endmodule

// ===== hdl/pglt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Packed group list table: sequencer
// Steps each request through its read, scan, shift and rewrite phases and
// owns both handshakes.
// ----------------------------------------------------------------------------
module pglt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  pglt_pkg::sts_t sts,
    output pglt_pkg::cmd_t cmd
);

    typedef enum logic [23:0] {
        S_CLEAR   = 24'd1 << 0,
        S_IDLE    = 24'd1 << 1,
        S_CHECK   = 24'd1 << 2,
        S_CREATE  = 24'd1 << 3,
        S_SPAN    = 24'd1 << 4,
        S_APPEND  = 24'd1 << 5,
        S_R7      = 24'd1 << 6,
        S_TEST_RD = 24'd1 << 7,
        S_TEST_CK = 24'd1 << 8,
        S_DM_RD   = 24'd1 << 9,
        S_DM_CK   = 24'd1 << 10,
        S_CUT_RD  = 24'd1 << 11,
        S_CUT_WR  = 24'd1 << 12,
        S_LOW_RD  = 24'd1 << 13,
        S_LOW_WR  = 24'd1 << 14,
        S_HOME_RD = 24'd1 << 15,
        S_HOME_WR = 24'd1 << 16,
        S_MVA_RD  = 24'd1 << 17,
        S_MVA_WR  = 24'd1 << 18,
        S_MVB_RD  = 24'd1 << 19,
        S_MVB_WR  = 24'd1 << 20,
        S_MVC_RD  = 24'd1 << 21,
        S_MVC_WR  = 24'd1 << 22,
        S_FINISH  = 24'd1 << 23
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;

    assign can_load = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pglt_pkg::OP_IDLE;
        cmd.take   = 1'b0;
        cmd.load   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = pglt_pkg::OP_CLEAR;
                if (sts.done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.op   = pglt_pkg::OP_IDLE;
                cmd.take = in_valid;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op = pglt_pkg::OP_CHECK;
                if (sts.mode == pglt_pkg::MODE_CREATE)
                    state_next = S_CREATE;
                else if (!sts.grp_ok)
                    state_next = S_FINISH;
                else
                    state_next = S_SPAN;
            end
            S_CREATE:
            begin
                cmd.op     = pglt_pkg::OP_CREATE;
                state_next = S_FINISH;
            end
            S_SPAN:
            begin
                cmd.op = pglt_pkg::OP_SPAN;
                unique case (sts.mode)
                    pglt_pkg::MODE_TEST:   state_next = S_TEST_RD;
                    pglt_pkg::MODE_APPEND: state_next = S_APPEND;
                    pglt_pkg::MODE_DROP_M: state_next = S_DM_RD;
                    pglt_pkg::MODE_DROP_G: state_next = S_CUT_RD;
                    pglt_pkg::MODE_MOVE:   state_next = sts.skip ? S_FINISH : S_MVA_RD;
                    pglt_pkg::MODE_READ:   state_next = sts.bad7 ? S_FINISH : S_R7;
                    default:               state_next = S_FINISH;
                endcase
            end
            S_APPEND:
            begin
                cmd.op     = pglt_pkg::OP_APPEND;
                state_next = S_FINISH;
            end
            S_R7:
            begin
                cmd.op     = pglt_pkg::OP_R7;
                state_next = S_FINISH;
            end
            S_TEST_RD:
            begin
                cmd.op     = pglt_pkg::OP_TEST_RD;
                state_next = sts.done ? S_FINISH : S_TEST_CK;
            end
            S_TEST_CK:
            begin
                cmd.op     = pglt_pkg::OP_TEST_CK;
                state_next = S_TEST_RD;
            end
            S_DM_RD:
            begin
                cmd.op     = pglt_pkg::OP_DM_RD;
                state_next = sts.done ? S_FINISH : S_DM_CK;
            end
            S_DM_CK:
            begin
                cmd.op     = pglt_pkg::OP_DM_CK;
                state_next = sts.hit ? S_CUT_RD : S_DM_RD;
            end
            S_CUT_RD:
            begin
                cmd.op = pglt_pkg::OP_CUT_RD;
                if (!sts.done)
                    state_next = S_CUT_WR;
                else if (sts.mode == pglt_pkg::MODE_DROP_G)
                    state_next = S_LOW_RD;
                else
                    state_next = S_FINISH;
            end
            S_CUT_WR:
            begin
                cmd.op     = pglt_pkg::OP_CUT_WR;
                state_next = S_CUT_RD;
            end
            S_LOW_RD:
            begin
                cmd.op = pglt_pkg::OP_LOW_RD;
                if (!sts.done)
                    state_next = S_LOW_WR;
                else if (sts.mode == pglt_pkg::MODE_DROP_G)
                    state_next = S_HOME_RD;
                else
                    state_next = S_FINISH;
            end
            S_LOW_WR:
            begin
                cmd.op     = pglt_pkg::OP_LOW_WR;
                state_next = S_LOW_RD;
            end
            S_HOME_RD:
            begin
                cmd.op     = pglt_pkg::OP_HOME_RD;
                state_next = sts.done ? S_FINISH : S_HOME_WR;
            end
            S_HOME_WR:
            begin
                cmd.op     = pglt_pkg::OP_HOME_WR;
                state_next = S_HOME_RD;
            end
            S_MVA_RD:
            begin
                cmd.op     = pglt_pkg::OP_MVA_RD;
                state_next = sts.done ? S_MVB_RD : S_MVA_WR;
            end
            S_MVA_WR:
            begin
                cmd.op     = pglt_pkg::OP_MVA_WR;
                state_next = S_MVA_RD;
            end
            S_MVB_RD:
            begin
                cmd.op     = pglt_pkg::OP_MVB_RD;
                state_next = sts.done ? S_MVC_RD : S_MVB_WR;
            end
            S_MVB_WR:
            begin
                cmd.op     = pglt_pkg::OP_MVB_WR;
                state_next = S_MVB_RD;
            end
            S_MVC_RD:
            begin
                cmd.op     = pglt_pkg::OP_MVC_RD;
                state_next = sts.done ? S_LOW_RD : S_MVC_WR;
            end
            S_MVC_WR:
            begin
                cmd.op     = pglt_pkg::OP_MVC_WR;
                state_next = S_MVC_RD;
            end
            S_FINISH:
            begin
                cmd.op   = pglt_pkg::OP_FINISH;
                cmd.load = can_load;
                if (can_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/packed_group_list_table_core.sv =====
// ----------------------------------------------------------------------------
// Packed group list table
// Groups of member ids packed in one buffer, with per-group start and size
// and a back-pointer per member id; one request in, one result out.
// ----------------------------------------------------------------------------
// Each request is handled alone: in_stall is high from acceptance until its
// result has been placed in the output register, which frees the block for
// the next request while the result waits for the consumer. Every buffer,
// record and back-pointer access goes through registered memory reads (one
// write and one read port per memory), so each element of a sweep takes a
// read step and then a write or compare step. Count, create, append and
// invalid-group requests need no sweep; test and drop member scan the group,
// and drop member then shifts the entries behind the removed one down; drop
// group shifts the entries behind the group down, rewrites the group records
// and sweeps all 1024 back-pointers; move to end copies the group to the
// scratch buffer, shifts the entries behind it down, writes the group back at
// the end and rewrites the group records. After reset the block clears all
// 1024 back-pointers, one per cycle, and accepts no request until it is done.
// ----------------------------------------------------------------------------
module packed_group_list_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pglt_pkg::MODE_W-1:0]    mode,
    input  logic [pglt_pkg::GROUP_W-1:0]   group,
    input  logic [pglt_pkg::MEMBER_W-1:0]  member,
    input  logic [pglt_pkg::POS_W-1:0]     position,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pglt_pkg::STATUS_W-1:0]  status,
    output logic                           found,
    output logic [pglt_pkg::VALUE_W-1:0]   value
);

    // sequencer commands and datapath flags
    pglt_pkg::cmd_t cmd;
    pglt_pkg::sts_t sts;

    pglt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage, sweep counters and result register
    pglt_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mode     (mode),
        .group    (group),
        .member   (member),
        .position (position),
        .sts      (sts),
        .status   (status),
        .found    (found),
        .value    (value)
    );

endmodule
